/* rtl/ulcm_pkg.sv */
// Shared types, constants and helper functions for the uplink command line matcher.
// Used by the line tracker, the top level and the checker; depends on nothing.
package ulcm_pkg;

   localparam int LineLengthDefault = 32;

   localparam logic [7:0] CharNewline = 8'h0a;
   localparam logic [7:0] CharReturn  = 8'h0d;
   localparam logic [7:0] CharNul     = 8'h00;

   localparam int TextChars = 8;
   // The text length saturates one above the longest command, which can never match.
   localparam logic [3:0] TextLenMax = 4'd9;

   typedef enum logic [1:0] {
      CODE_NONE   = 2'd0,
      CODE_ABORT  = 2'd1,
      CODE_DEPLOY = 2'd2
   } code_type;

   typedef enum logic [1:0] {
      CSR_ABORT_TEXT    = 2'd0,
      CSR_ABORT_LENGTH  = 2'd1,
      CSR_DEPLOY_TEXT   = 2'd2,
      CSR_DEPLOY_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [63:0] abort_text;
      logic [3:0]  abort_length;
      logic [63:0] deploy_text;
      logic [3:0]  deploy_length;
   } cmd_cfg_type;

   // Stated length capped at eight, cut at the first zero byte.
   function automatic logic [3:0] effective_length(logic [63:0] text, logic [3:0] length);
      logic [3:0] limit;
      logic [3:0] result;
      logic       stopped;
      limit   = (length > 4'd8) ? 4'd8 : length;
      result  = 4'd0;
      stopped = 1'b0;
      for (int i = 0; i < TextChars; i++) begin
         if (!stopped && (4'(i) < limit) && (text[8*i +: 8] != CharNul)) begin
            result = 4'(i + 1);
         end else begin
            stopped = 1'b1;
         end
      end
      return result;
   endfunction

endpackage

/* rtl/uplink_command_line_matcher_top.sv */
// Top level of the uplink command line matcher: command registers, line tracker
// and the result register. Depends on ulcm_pkg and ulcm_line.
//
// Usage: received bytes arrive one beat at a time on the req_ channel. Carriage
// returns are skipped, and a newline closes the line. Every newline produces
// exactly one beat on the rsp_ channel carrying the command code (none, abort or
// force deploy); no other byte produces a result. The line is compared against
// the two command texts character by character as it arrives, so no line buffer
// is kept. A line that fills up to LINE_LENGTH-1 characters is restarted by the
// next byte that is not a newline, and that byte is dropped.
//
// The result beat is registered and is presented in the cycle after the newline
// beat is accepted. Throughput: one byte per cycle while req_stall is low; the line
// state is updated on every accepted byte and the result register holds one entry.
//
// Stall: while a result is held by rsp_stall, req_stall is raised, so input
// waits until the result register frees. A result taken in a cycle frees the
// register in that same cycle, so streaming continues without a gap.
//
// Reset (synchronous, active high) clears the command registers to zero, empties
// the line and drops any pending result. The user must write the csr_ port only
// while the block is idle; the block itself does not enforce this.
module uplink_command_line_matcher_top #(
   parameter int LINE_LENGTH = ulcm_pkg::LineLengthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_received_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_command_code,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   ulcm_pkg::cmd_cfg_type cfg_ff, cfg_in;

   logic               rsp_valid_ff, rsp_valid_in;
   ulcm_pkg::code_type rsp_code_ff, rsp_code_in;

   logic               req_beat;
   logic               line_done;
   ulcm_pkg::code_type line_code;

   // Command registers; each write lands in the register picked by the index.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (ulcm_pkg::csr_index_type'(csr_index))
            ulcm_pkg::CSR_ABORT_TEXT:    cfg_in.abort_text    = csr_write_data;
            ulcm_pkg::CSR_ABORT_LENGTH:  cfg_in.abort_length  = csr_write_data[3:0];
            ulcm_pkg::CSR_DEPLOY_TEXT:   cfg_in.deploy_text   = csr_write_data;
            ulcm_pkg::CSR_DEPLOY_LENGTH: cfg_in.deploy_length = csr_write_data[3:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input is held back only while a finished result is itself held.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_beat  = req_valid && !req_stall;

   ulcm_line #(
      .LINE_LENGTH(LINE_LENGTH)
   ) u_line (
      .clock     (clock),
      .reset     (reset),
      .beat      (req_beat),
      .data_byte (req_received_byte),
      .cfg       (cfg_ff),
      .line_done (line_done),
      .line_code (line_code)
   );

   // Result register: loads on a newline beat, empties when the result is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      if (line_done) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = line_code;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_code = rsp_code_ff;

endmodule

/* rtl/ulcm_line.sv */
// Line state tracker: position, text length and the two running match flags.
// Depends on ulcm_pkg.
module ulcm_line #(
   parameter int LINE_LENGTH = ulcm_pkg::LineLengthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  beat,
   input  logic [7:0]            data_byte,
   input  ulcm_pkg::cmd_cfg_type cfg,
   output logic                  line_done,
   output ulcm_pkg::code_type    line_code
);

   localparam int PosW = (LINE_LENGTH > 2) ? $clog2(LINE_LENGTH) : 1;
   localparam logic [PosW-1:0] LastPos = PosW'(LINE_LENGTH - 1);

   logic [PosW-1:0] position_ff, position_in;
   logic [3:0]      text_len_ff, text_len_in;
   logic            ended_ff, ended_in;
   logic            abort_ok_ff, abort_ok_in;
   logic            deploy_ok_ff, deploy_ok_in;

   logic [3:0] abort_eff;
   logic [3:0] deploy_eff;
   logic       abort_char_ok;
   logic       deploy_char_ok;
   logic [2:0] char_sel;

   assign abort_eff  = ulcm_pkg::effective_length(cfg.abort_text, cfg.abort_length);
   assign deploy_eff = ulcm_pkg::effective_length(cfg.deploy_text, cfg.deploy_length);
   assign char_sel   = text_len_ff[2:0];

   // An index at or past the effective length never matches, which also covers
   // the saturated text length.
   assign abort_char_ok  = (text_len_ff < abort_eff) &&
                           (cfg.abort_text[8*char_sel +: 8] == data_byte);
   assign deploy_char_ok = (text_len_ff < deploy_eff) &&
                           (cfg.deploy_text[8*char_sel +: 8] == data_byte);

   assign line_done = beat && (data_byte == ulcm_pkg::CharNewline);

   always_comb begin
      if (abort_ok_ff && (text_len_ff == abort_eff)) begin
         line_code = ulcm_pkg::CODE_ABORT;
      end else if (deploy_ok_ff && (text_len_ff == deploy_eff)) begin
         line_code = ulcm_pkg::CODE_DEPLOY;
      end else begin
         line_code = ulcm_pkg::CODE_NONE;
      end
   end

   always_comb begin
      position_in  = position_ff;
      text_len_in  = text_len_ff;
      ended_in     = ended_ff;
      abort_ok_in  = abort_ok_ff;
      deploy_ok_in = deploy_ok_ff;
      if (beat) begin
         if ((data_byte == ulcm_pkg::CharNewline) || (position_ff == LastPos)) begin
            position_in  = '0;
            text_len_in  = '0;
            ended_in     = 1'b0;
            abort_ok_in  = 1'b1;
            deploy_ok_in = 1'b1;
         end else if (data_byte != ulcm_pkg::CharReturn) begin
            position_in = position_ff + 1'b1;
            if (!ended_ff) begin
               if (data_byte == ulcm_pkg::CharNul) begin
                  ended_in = 1'b1;
               end else begin
                  abort_ok_in  = abort_ok_ff && abort_char_ok;
                  deploy_ok_in = deploy_ok_ff && deploy_char_ok;
                  if (text_len_ff != ulcm_pkg::TextLenMax) begin
                     text_len_in = text_len_ff + 4'd1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         text_len_ff  <= '0;
         ended_ff     <= 1'b0;
         abort_ok_ff  <= 1'b1;
         deploy_ok_ff <= 1'b1;
      end else begin
         position_ff  <= position_in;
         text_len_ff  <= text_len_in;
         ended_ff     <= ended_in;
         abort_ok_ff  <= abort_ok_in;
         deploy_ok_ff <= deploy_ok_in;
      end
   end

endmodule

/* rtl/ulcm_checker.sv */
// Port-level checker for the uplink command line matcher, bound to the top level.
// Depends on ulcm_pkg and uplink_command_line_matcher_top.
module ulcm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_received_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_command_code
);

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   // A held result keeps its code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command_code))
      else $error("held result changed or vanished");

   // Every accepted newline shows a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_received_byte == ulcm_pkg::CharNewline) |=> rsp_valid)
      else $error("newline beat produced no result");

   // Any other byte never produces a result of its own.
   assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_received_byte != ulcm_pkg::CharNewline) && !(rsp_valid && rsp_stall)
      |=> !rsp_valid)
      else $error("result appeared without a newline");

   // Input is only held back behind a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   // The code is one of the three defined values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_command_code == ulcm_pkg::CODE_NONE) ||
                    (rsp_command_code == ulcm_pkg::CODE_ABORT) ||
                    (rsp_command_code == ulcm_pkg::CODE_DEPLOY))
      else $error("undefined command code");

endmodule

bind uplink_command_line_matcher_top ulcm_checker u_ulcm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_received_byte (req_received_byte),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_command_code  (rsp_command_code)
);

/* sim/tb_uplink_command_line_matcher_top.sv */
// Self-checking testbench for uplink_command_line_matcher_top: streams received bytes,
// predicts the command code of every finished line and checks each result beat.
// Depends on ulcm_pkg and the RTL of the matcher; needs nothing else.
module tb_uplink_command_line_matcher_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LineLength  = ulcm_pkg::LineLengthDefault;
   localparam int CycleLimit  = 200000;
   localparam int MaxReported = 10;

   // Shapes of generated lines. Most are well formed so the match logic is reached.
   typedef enum int {
      LINE_ABORT,
      LINE_DEPLOY,
      LINE_NUL_TAIL,
      LINE_NEAR_MISS,
      LINE_OVERFLOW,
      LINE_NOISE,
      LINE_EMPTY
   } line_kind_type;

   typedef enum int {
      STALL_NONE,
      STALL_SCATTER,
      STALL_RUNS
   } stall_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_received_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_command_code;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;

   // Shadow copy of the command registers, updated whenever the bench writes one.
   logic [63:0] cfg_abort_text;
   logic [3:0]  cfg_abort_len;
   logic [63:0] cfg_deploy_text;
   logic [3:0]  cfg_deploy_len;

   // Predicted line state. The position has the width of the block's; the text length is wider and does not saturate.
   logic [4:0]  line_pos;
   logic [4:0]  text_len;
   logic        text_done;
   logic        abort_ok;
   logic        deploy_ok;

   // Command codes still owed by the block, oldest first.
   ulcm_pkg::code_type expected_codes[$];
   logic [7:0]  line_buf[$];

   stall_mode_type stall_mode = STALL_NONE;
   int          stall_run   = 0;
   logic        stall_state = 1'b0;
   bit          gaps_on     = 1'b1;
   int          burst_left  = 0;

   int          bytes_sent      = 0;
   int          lines_sent      = 0;
   int          settings_used   = 0;
   int          results_checked = 0;
   int          abort_count     = 0;
   int          deploy_count    = 0;
   int          none_count      = 0;
   int          mismatch_count  = 0;

   uplink_command_line_matcher_top #(
      .LINE_LENGTH(LineLength)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_received_byte(req_received_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command_code (rsp_command_code),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // 12 ns period. Stimulus moves on the falling edge, the DUT samples on the rising one.
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Line predictor
   // ------------------------------------------------------------------

   // Number of characters a command text really has: the stated length, capped at
   // eight, and cut short by the first zero byte inside it.
   function automatic logic [3:0] usable_chars(input logic [63:0] text, input logic [3:0] len);
      int limit;
      int n;
      limit = (len > 4'd8) ? 8 : int'(len);
      n = 0;
      while (n < limit && text[8*n +: 8] != ulcm_pkg::CharNul) n++;
      return 4'(n);
   endfunction

   function automatic bit char_agrees(input logic [63:0] text, input logic [3:0] len,
                                      input logic [4:0] idx, input logic [7:0] value);
      if (idx >= 5'(usable_chars(text, len))) return 1'b0;
      return text[8*idx +: 8] == value;
   endfunction

   function automatic void restart_line();
      line_pos  = '0;
      text_len  = '0;
      text_done = 1'b0;
      abort_ok  = 1'b1;
      deploy_ok = 1'b1;
   endfunction

   // Advance the predicted line by one accepted byte. A newline closes the line and
   // queues its command code; abort is tried first, so it wins when both agree.
   function automatic void advance_line(input logic [7:0] value);
      ulcm_pkg::code_type code;
      if (value == ulcm_pkg::CharNewline) begin
         code = ulcm_pkg::CODE_NONE;
         if (abort_ok && text_len == 5'(usable_chars(cfg_abort_text, cfg_abort_len))) begin
            code = ulcm_pkg::CODE_ABORT;
         end else if (deploy_ok &&
                      text_len == 5'(usable_chars(cfg_deploy_text, cfg_deploy_len))) begin
            code = ulcm_pkg::CODE_DEPLOY;
         end
         expected_codes.push_back(code);
         restart_line();
      end else if (line_pos >= 5'(LineLength - 1)) begin
         // A full line swallows this byte, carriage return included, and starts over.
         restart_line();
      end else if (value != ulcm_pkg::CharReturn) begin
         line_pos = line_pos + 5'd1;
         if (!text_done) begin
            if (value == ulcm_pkg::CharNul) begin
               text_done = 1'b1;
            end else begin
               if (!char_agrees(cfg_abort_text, cfg_abort_len, text_len, value)) abort_ok = 1'b0;
               if (!char_agrees(cfg_deploy_text, cfg_deploy_len, text_len, value)) begin
                  deploy_ok = 1'b0;
               end
               text_len = text_len + 5'd1;
            end
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Result side: stall pattern and checker
   // ------------------------------------------------------------------

   // The receiver either never stalls, stalls on scattered cycles, or alternates
   // runs of stall and no stall of random length.
   always @(negedge clock) begin
      if (reset || stall_mode == STALL_NONE) begin
         rsp_stall <= 1'b0;
      end else if (stall_mode == STALL_SCATTER) begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
      end else begin
         if (stall_run == 0) begin
            stall_state = ~stall_state;
            stall_run   = $urandom_range(1, 12);
         end
         stall_run--;
         rsp_stall <= stall_state;
      end
   end

   // Every accepted result beat is matched against the oldest predicted code.
   always @(posedge clock) begin
      ulcm_pkg::code_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (expected_codes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported) begin
               $display("Unexpected result beat: command code %0d with no line pending",
                        rsp_command_code);
            end
         end else begin
            want = expected_codes.pop_front();
            if (rsp_command_code !== want) begin
               mismatch_count++;
               if (mismatch_count <= MaxReported) begin
                  $display("Command code mismatch: expected %0d, got %0d", want,
                           rsp_command_code);
               end
            end
            case (want)
               ulcm_pkg::CODE_ABORT:  abort_count++;
               ulcm_pkg::CODE_DEPLOY: deploy_count++;
               default:               none_count++;
            endcase
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("Run stopped after %0d cycles without finishing", CycleLimit);
      $display("tb_uplink_command_line_matcher_top failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Sender side. All tasks start and end on a falling edge.
   // ------------------------------------------------------------------

   // Send one byte beat. While gaps are on, the sender works in bursts; between bursts
   // valid drops and the payload is scrambled, which the DUT must ignore.
   task automatic send_byte(input logic [7:0] value);
      if (gaps_on && burst_left == 0) begin
         req_valid         <= 1'b0;
         req_received_byte <= 8'($urandom);
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_valid         <= 1'b1;
      req_received_byte <= value;
      // The payload is held until the beat is taken.
      do @(posedge clock); while (req_stall);
      advance_line(value);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Stop sending and wait until every owed result has been taken, then let the
   // result register settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_codes.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      burst_left = 0;
   endtask

   // One register write. Enable is raised for a single edge and the port is then left
   // quiet before the task returns, so back-to-back writes never collide on a signal.
   task automatic write_register(input ulcm_pkg::csr_index_type idx, input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         ulcm_pkg::CSR_ABORT_TEXT:    cfg_abort_text  = data;
         ulcm_pkg::CSR_ABORT_LENGTH:  cfg_abort_len   = data[3:0];
         ulcm_pkg::CSR_DEPLOY_TEXT:   cfg_deploy_text = data;
         default:                     cfg_deploy_len  = data[3:0];
      endcase
      @(negedge clock);
   endtask

   // Program both commands while the block is idle. Upper bits of the length words
   // carry random junk, which the block must discard.
   task automatic configure_all(input logic [63:0] at, input logic [3:0] al,
                                input logic [63:0] dt, input logic [3:0] dl);
      logic [63:0] word;
      drain_results();
      write_register(ulcm_pkg::CSR_ABORT_TEXT, at);
      word      = {$urandom, $urandom};
      word[3:0] = al;
      write_register(ulcm_pkg::CSR_ABORT_LENGTH, word);
      write_register(ulcm_pkg::CSR_DEPLOY_TEXT, dt);
      word      = {$urandom, $urandom};
      word[3:0] = dl;
      write_register(ulcm_pkg::CSR_DEPLOY_LENGTH, word);
      settings_used++;
   endtask

   // A random command text: printable, fully random, printable with a zero byte
   // inside its length, or printable with a length above eight.
   task automatic make_command(output logic [63:0] text, output logic [3:0] len);
      int style;
      int spot;
      style = $urandom_range(0, 3);
      text  = {$urandom, $urandom};
      len   = 4'($urandom_range(0, 8));
      if (style != 1) begin
         for (int i = 0; i < ulcm_pkg::TextChars; i++) begin
            text[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7e));
         end
      end
      if (style == 1) len = 4'($urandom);
      if (style == 2 && len > 0) begin
         spot = $urandom_range(0, int'(len) - 1);
         text[8*spot +: 8] = ulcm_pkg::CharNul;
      end
      if (style == 3) len = 4'($urandom_range(9, 15));
   endtask

   function automatic logic [7:0] line_char();
      logic [7:0] v;
      do v = 8'($urandom); while (v == ulcm_pkg::CharNewline);
      return v;
   endfunction

   task automatic push_command(input bit use_abort);
      logic [63:0] text;
      logic [3:0]  n;
      text = use_abort ? cfg_abort_text : cfg_deploy_text;
      n    = use_abort ? usable_chars(cfg_abort_text, cfg_abort_len)
                       : usable_chars(cfg_deploy_text, cfg_deploy_len);
      for (int i = 0; i < int'(n); i++) line_buf.push_back(text[8*i +: 8]);
   endtask

   function automatic line_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 24) return LINE_ABORT;
      if (r < 48) return LINE_DEPLOY;
      if (r < 58) return LINE_NUL_TAIL;
      if (r < 78) return LINE_NEAR_MISS;
      if (r < 87) return LINE_OVERFLOW;
      if (r < 96) return LINE_NOISE;
      return LINE_EMPTY;
   endfunction

   // Build one line of the given shape, sprinkle carriage returns into it and send
   // it, normally closed by a newline.
   task automatic send_line(input line_kind_type kind);
      int pos;
      bit close;
      line_buf.delete();
      close = 1'b1;
      case (kind)
         LINE_ABORT:  push_command(1'b1);
         LINE_DEPLOY: push_command(1'b0);
         LINE_NUL_TAIL: begin
            // Everything after the zero byte still fills the line but is not compared.
            push_command($urandom_range(0, 1));
            line_buf.push_back(ulcm_pkg::CharNul);
            repeat ($urandom_range(0, 5)) line_buf.push_back(line_char());
         end
         LINE_NEAR_MISS: begin
            push_command($urandom_range(0, 1));
            case ($urandom_range(0, 2))
               0: if (line_buf.size() > 0) void'(line_buf.pop_back());
               1: line_buf.push_back(line_char());
               default: if (line_buf.size() > 0) begin
                  pos = $urandom_range(0, line_buf.size() - 1);
                  line_buf[pos] = line_buf[pos] ^ 8'($urandom_range(1, 255));
               end
            endcase
         end
         LINE_OVERFLOW: begin
            // Fill the line, let the next byte restart it, then often a real command.
            repeat (LineLength - 1 + $urandom_range(0, 2)) line_buf.push_back(line_char());
            if ($urandom_range(0, 2) != 0) push_command($urandom_range(0, 1));
         end
         LINE_NOISE: begin
            repeat ($urandom_range(0, 12)) line_buf.push_back(8'($urandom));
            close = ($urandom_range(0, 5) != 0);
         end
         default: ;
      endcase
      for (int i = 0; i < line_buf.size(); i++) begin
         if ($urandom_range(0, 9) == 0) send_byte(ulcm_pkg::CharReturn);
         send_byte(line_buf[i]);
      end
      if (close) send_byte(ulcm_pkg::CharNewline);
      lines_sent++;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Straight out of reset both command texts are empty, so an empty line, a line of
   // only a carriage return, and a line that starts with a zero byte all give abort.
   task automatic test_power_on_defaults();
      gaps_on    = 1'b1;
      stall_mode = STALL_SCATTER;
      send_byte(ulcm_pkg::CharNewline);
      send_text("x\n");
      send_byte(ulcm_pkg::CharReturn);
      send_byte(ulcm_pkg::CharNewline);
      send_byte(ulcm_pkg::CharNul);
      send_text("Q\n");
   endtask

   // Exact matches, abort winning a tie, skipped carriage returns, a length above
   // eight and a zero byte inside a command text.
   task automatic test_command_match();
      configure_all(64'h0000_0000_0000_4241, 4'd2, 64'h0000_0000_0000_4241, 4'd2);
      send_text("AB\n");
      configure_all(64'h0000_0000_0000_4241, 4'd2, 64'h0000_0000_0043_4241, 4'd3);
      send_text("A");
      send_byte(ulcm_pkg::CharReturn);
      send_text("BC\n");
      send_text("ABX\n");
      send_text("A\n");
      // Abort "XYZ" with length 9 (taken as 8, cut at the zero); deploy "AB", zero, "D".
      configure_all(64'h0000_0000_005a_5958, 4'd9, 64'h0000_0000_4400_4241, 4'd4);
      send_text("XYZ\n");
      send_text("AB\n");
      send_text("AB");
      send_byte(ulcm_pkg::CharNul);
      send_text("D\n");
   endtask

   // A full line drops the next byte, even a carriage return, and restarts empty.
   task automatic test_line_overflow();
      stall_mode = STALL_RUNS;
      repeat (LineLength - 1) send_byte(8'h7a);
      send_byte(ulcm_pkg::CharReturn);
      send_text("XYZ\n");
      repeat (LineLength - 1) send_byte(8'h7a);
      send_byte(ulcm_pkg::CharNewline);
   endtask

   // Registers rewritten with a line half done: characters already taken keep their
   // old comparison, and the newline is checked against the new length.
   task automatic test_mid_line_write();
      configure_all(64'h0000_0000_0043_4241, 4'd3, 64'h0, 4'd0);
      send_text("AB");
      drain_results();
      write_register(ulcm_pkg::CSR_ABORT_LENGTH, 64'd2);
      send_byte(ulcm_pkg::CharNewline);
      send_text("A");
      drain_results();
      write_register(ulcm_pkg::CSR_ABORT_TEXT, 64'h0000_0000_0000_5141);
      send_text("Q\n");
   endtask

   // Random lines over a series of register settings, the extremes first. Idling on
   // both sides changes from one setting to the next.
   task automatic test_random_traffic();
      logic [63:0] at;
      logic [63:0] dt;
      logic [3:0]  al;
      logic [3:0]  dl;
      int          phase_end;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin
               at = '0; al = 4'd0; dt = '0; dl = 4'd0;
            end
            1: begin
               at = '1; al = 4'd8; dt = '1; dl = 4'd15;
            end
            2: begin
               make_command(at, al);
               al = 4'd0;
               make_command(dt, dl);
               dl = 4'd8;
            end
            3: begin
               // Deploy uses the abort text with length eight, so it is at least as long as abort.
               make_command(at, al);
               dt = at;
               dl = 4'd8;
            end
            default: begin
               make_command(at, al);
               make_command(dt, dl);
            end
         endcase
         configure_all(at, al, dt, dl);
         gaps_on    = (phase % 4 != 3);
         stall_mode = stall_mode_type'(phase % 3);
         phase_end  = bytes_sent + 75;
         while (bytes_sent < phase_end) begin
            send_line(pick_kind());
            // Now and then hold off until the block has caught up completely.
            if ($urandom_range(0, 19) == 0) drain_results();
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_received_byte = '0;
      csr_write_enable  = 1'b0;
      csr_index         = '0;
      csr_write_data    = '0;
      cfg_abort_text    = '0;
      cfg_abort_len     = '0;
      cfg_deploy_text   = '0;
      cfg_deploy_len    = '0;
      restart_line();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_power_on_defaults();
      test_command_match();
      test_line_overflow();
      test_mid_line_write();
      test_random_traffic();

      drain_results();
      repeat (4) @(negedge clock);

      $display("Sent %0d bytes in %0d generated lines across %0d register settings.",
               bytes_sent, lines_sent, settings_used);
      $display("Checked %0d result beats: %0d abort, %0d force deploy, %0d none.",
               results_checked, abort_count, deploy_count, none_count);
      if (mismatch_count == 0 && expected_codes.size() == 0) begin
         $display("tb_uplink_command_line_matcher_top passed");
      end else begin
         $display("%0d mismatches, %0d results never delivered", mismatch_count,
                  expected_codes.size());
         $display("tb_uplink_command_line_matcher_top failed");
      end
      $finish;
   end

endmodule
